// File: rtl/scl_pkg.sv
// Shared types and operation codes for the shape collision tester.
`default_nettype none
package scl_pkg;

   // Test selector carried by every request.
   typedef enum logic [1:0] {
      OP_RECT_RECT     = 2'd0,
      OP_CIRCLE_CIRCLE = 2'd1,
      OP_RECT_CIRCLE   = 2'd2
   } op_type;

   // Tests already settled in the first stage, passed to the compare stage.
   typedef struct packed {
      logic rect_hit;    // rectangle-rectangle overlap on both axes
      logic contained;   // circle centre inside the rectangle
      logic edge_hit;    // an edge of the rectangle lies within one radius
   } flags_type;

endpackage
`default_nettype wire

// File: rtl/scl_square.sv
// First stage: doubled-coordinate differences, range tests and registered squares.
`default_nettype none
module scl_square #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          valid,
   input  wire scl_pkg::op_type               operation,
   input  wire logic signed [COORD_WIDTH-1:0] first_x,
   input  wire logic signed [COORD_WIDTH-1:0] first_y,
   input  wire logic        [COORD_WIDTH-2:0] first_extent_x,
   input  wire logic        [COORD_WIDTH-2:0] first_extent_y,
   input  wire logic signed [COORD_WIDTH-1:0] second_x,
   input  wire logic signed [COORD_WIDTH-1:0] second_y,
   input  wire logic        [COORD_WIDTH-2:0] second_extent_x,
   input  wire logic        [COORD_WIDTH-2:0] second_extent_y,
   output logic                               valid_out,
   output scl_pkg::op_type                    operation_out,
   output scl_pkg::flags_type                 flags_out,
   output logic [2*COORD_WIDTH+3:0]           sq_a,
   output logic [2*COORD_WIDTH+3:0]           sq_b,
   output logic [2*COORD_WIDTH+3:0]           sq_c,
   output logic [2*COORD_WIDTH+3:0]           sq_d,
   output logic [2*COORD_WIDTH-1:0]           sq_e
);
   import scl_pkg::*;

   localparam int D  = COORD_WIDTH + 3;   // signed doubled differences
   localparam int M  = COORD_WIDTH + 2;   // their magnitudes
   localparam int SQ = 2 * M;
   localparam int SE = 2 * COORD_WIDTH;

   logic signed [D-1:0] ax, ay, bx, by, aex, aey;
   logic signed [D-1:0] xl, xr, yt, yb, cx, cy;
   logic signed [D-1:0] el, er, et, eb, dx, dy;
   logic [M-1:0]        mag_el, mag_er, mag_et, mag_eb, mag_dx, mag_dy;
   logic [M-1:0]        mag_a, mag_c, r2_ext;
   logic [COORD_WIDTH-1:0] radius_sum, radius_two, mag_e;
   logic [D-1:0]        width_sum, height_sum;
   logic                horiz, vert;

   logic                valid_ff, valid_in;
   op_type              operation_ff;
   flags_type           flags_ff, flags_in;
   logic [SQ-1:0]       sq_a_ff, sq_b_ff, sq_c_ff, sq_d_ff;
   logic [SQ-1:0]       sq_a_in, sq_b_in, sq_c_in, sq_d_in;
   logic [SE-1:0]       sq_e_ff, sq_e_in;

   always_comb begin
      ax  = D'(first_x);
      ay  = D'(first_y);
      bx  = D'(second_x);
      by  = D'(second_y);
      aex = $signed({4'b0000, first_extent_x});
      aey = $signed({4'b0000, first_extent_y});

      // Rectangle edges and circle centre, all at twice the scale.
      cx = bx <<< 1;
      cy = by <<< 1;
      xl = (ax <<< 1) - aex;
      xr = (ax <<< 1) + aex;
      yt = (ay <<< 1) - aey;
      yb = (ay <<< 1) + aey;
      el = xl - cx;
      er = xr - cx;
      et = yt - cy;
      eb = yb - cy;
      dx = ax - bx;
      dy = ay - by;

      mag_el = el[D-1] ? M'(-el) : M'(el);
      mag_er = er[D-1] ? M'(-er) : M'(er);
      mag_et = et[D-1] ? M'(-et) : M'(et);
      mag_eb = eb[D-1] ? M'(-eb) : M'(eb);
      mag_dx = dx[D-1] ? M'(-dx) : M'(dx);
      mag_dy = dy[D-1] ? M'(-dy) : M'(dy);

      radius_sum = COORD_WIDTH'(first_extent_x) + COORD_WIDTH'(second_extent_x);
      radius_two = {second_extent_x, 1'b0};
      r2_ext     = M'(radius_two);

      horiz = (cx >= xl) && (cx <= xr);
      vert  = (cy >= yt) && (cy <= yb);

      width_sum  = D'(first_extent_x) + D'(second_extent_x);
      height_sum = D'(first_extent_y) + D'(second_extent_y);

      flags_in.rect_hit  = ({mag_dx, 1'b0} <= {1'b0, width_sum}) &&
                           ({mag_dy, 1'b0} <= {1'b0, height_sum});
      flags_in.contained = horiz && vert;
      flags_in.edge_hit  = (horiz && (first_y >= second_y) && (mag_et <= r2_ext)) ||
                           (horiz && (first_y <= second_y) && (mag_eb <= r2_ext)) ||
                           (vert  && (first_x >= second_x) && (mag_el <= r2_ext)) ||
                           (vert  && (first_x <= second_x) && (mag_er <= r2_ext));

      // The circle-circle test borrows the first, third and fifth multipliers.
      if (operation == OP_CIRCLE_CIRCLE) begin
         mag_a = mag_dx;
         mag_c = mag_dy;
         mag_e = radius_sum;
      end else begin
         mag_a = mag_el;
         mag_c = mag_et;
         mag_e = radius_two;
      end

      sq_a_in  = SQ'(mag_a) * SQ'(mag_a);
      sq_b_in  = SQ'(mag_er) * SQ'(mag_er);
      sq_c_in  = SQ'(mag_c) * SQ'(mag_c);
      sq_d_in  = SQ'(mag_eb) * SQ'(mag_eb);
      sq_e_in  = SE'(mag_e) * SE'(mag_e);
      valid_in = valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      operation_ff <= operation;
      flags_ff     <= flags_in;
      sq_a_ff      <= sq_a_in;
      sq_b_ff      <= sq_b_in;
      sq_c_ff      <= sq_c_in;
      sq_d_ff      <= sq_d_in;
      sq_e_ff      <= sq_e_in;
   end

   assign valid_out     = valid_ff;
   assign operation_out = operation_ff;
   assign flags_out     = flags_ff;
   assign sq_a          = sq_a_ff;
   assign sq_b          = sq_b_ff;
   assign sq_c          = sq_c_ff;
   assign sq_d          = sq_d_ff;
   assign sq_e          = sq_e_ff;
endmodule
`default_nettype wire

// File: rtl/scl_decide.sv
// Second stage: squared-distance compares and the registered collision result.
`default_nettype none
module scl_decide #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       valid,
   input  wire scl_pkg::op_type            operation,
   input  wire scl_pkg::flags_type         flags,
   input  wire logic [2*COORD_WIDTH+3:0]   sq_a,
   input  wire logic [2*COORD_WIDTH+3:0]   sq_b,
   input  wire logic [2*COORD_WIDTH+3:0]   sq_c,
   input  wire logic [2*COORD_WIDTH+3:0]   sq_d,
   input  wire logic [2*COORD_WIDTH-1:0]   sq_e,
   output logic                            valid_out,
   output logic                            collides
);
   import scl_pkg::*;

   localparam int S = 2 * COORD_WIDTH + 5;

   logic [S-1:0] sum_ac, sum_bc, sum_ad, sum_bd, limit;
   logic         corner_hit, hit;
   logic         valid_ff, valid_in, collides_ff, collides_in;

   always_comb begin
      sum_ac = S'(sq_a) + S'(sq_c);
      sum_bc = S'(sq_b) + S'(sq_c);
      sum_ad = S'(sq_a) + S'(sq_d);
      sum_bd = S'(sq_b) + S'(sq_d);
      limit  = S'(sq_e);

      corner_hit = (sum_ac <= limit) || (sum_bc <= limit) ||
                   (sum_ad <= limit) || (sum_bd <= limit);

      case (operation)
         OP_RECT_RECT:     hit = flags.rect_hit;
         OP_CIRCLE_CIRCLE: hit = (sum_ac <= limit);
         OP_RECT_CIRCLE:   hit = flags.contained || flags.edge_hit || corner_hit;
         default:          hit = 1'b0;
      endcase

      valid_in    = valid;
      collides_in = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      collides_ff <= collides_in;
   end

   assign valid_out = valid_ff;
   assign collides  = collides_ff;
endmodule
`default_nettype wire

// File: rtl/shape_collision_tester_unit.sv
// Top level of the shape collision tester: request register and two compute stages.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_*            taken when start is high and busy is low
//   response  rsp_valid, rsp_collides       one-cycle strobe, cannot be held off
//
// A request is taken every cycle; busy is always low.
// Each result passes through the request register, the square register (one
// multiplier per path), then the compare and the result register.
// Reset clears only the valid pipeline; the data registers are not reset.
// Results leave in request order and the receiver cannot stall the pipeline.
`default_nettype none
module shape_collision_tester_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_operation,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_y,
   input  wire logic        [COORD_WIDTH-2:0] req_first_extent_x,
   input  wire logic        [COORD_WIDTH-2:0] req_first_extent_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_y,
   input  wire logic        [COORD_WIDTH-2:0] req_second_extent_x,
   input  wire logic        [COORD_WIDTH-2:0] req_second_extent_y,
   output logic                               rsp_valid,
   output logic                               rsp_collides
);
   import scl_pkg::*;

   logic                          req_valid_ff, req_valid_in;
   logic [1:0]                    operation_ff;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic [COORD_WIDTH-2:0]        first_ex_ff, first_ey_ff, second_ex_ff, second_ey_ff;

   logic                   mid_valid;
   op_type                 mid_operation;
   flags_type              mid_flags;
   logic [2*COORD_WIDTH+3:0] sq_a, sq_b, sq_c, sq_d;
   logic [2*COORD_WIDTH-1:0] sq_e;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      operation_ff <= req_operation;
      first_x_ff   <= req_first_x;
      first_y_ff   <= req_first_y;
      first_ex_ff  <= req_first_extent_x;
      first_ey_ff  <= req_first_extent_y;
      second_x_ff  <= req_second_x;
      second_y_ff  <= req_second_y;
      second_ex_ff <= req_second_extent_x;
      second_ey_ff <= req_second_extent_y;
   end

   scl_square #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_square (
      .clock           (clock),
      .reset           (reset),
      .valid           (req_valid_ff),
      .operation       (op_type'(operation_ff)),
      .first_x         (first_x_ff),
      .first_y         (first_y_ff),
      .first_extent_x  (first_ex_ff),
      .first_extent_y  (first_ey_ff),
      .second_x        (second_x_ff),
      .second_y        (second_y_ff),
      .second_extent_x (second_ex_ff),
      .second_extent_y (second_ey_ff),
      .valid_out       (mid_valid),
      .operation_out   (mid_operation),
      .flags_out       (mid_flags),
      .sq_a            (sq_a),
      .sq_b            (sq_b),
      .sq_c            (sq_c),
      .sq_d            (sq_d),
      .sq_e            (sq_e)
   );

   scl_decide #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_decide (
      .clock     (clock),
      .reset     (reset),
      .valid     (mid_valid),
      .operation (mid_operation),
      .flags     (mid_flags),
      .sq_a      (sq_a),
      .sq_b      (sq_b),
      .sq_c      (sq_c),
      .sq_d      (sq_d),
      .sq_e      (sq_e),
      .valid_out (rsp_valid),
      .collides  (rsp_collides)
   );
endmodule
`default_nettype wire

// File: sim/collision_checker.sv
// Checker for the shape collision tester: predicts each response and compares it.
module collision_checker #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic        [COORD_WIDTH-2:0] req_first_extent_x,
   input  logic        [COORD_WIDTH-2:0] req_first_extent_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic        [COORD_WIDTH-2:0] req_second_extent_x,
   input  logic        [COORD_WIDTH-2:0] req_second_extent_y,
   input  logic                          rsp_valid,
   input  logic                          rsp_collides,
   output int                            mismatches,
   output int                            pending
);
   import scl_pkg::*;

   bit expected_collides[$];
   int error_count = 0;

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Exact test of dx^2 + dy^2 <= r^2; every term fits easily in 64 bits.
   function automatic bit within_radius(longint dx, longint dy, longint r);
      return (dx * dx + dy * dy) <= (r * r);
   endfunction

   function automatic bit predict_collision(
      logic [1:0] operation,
      longint ax, longint ay, longint aex, longint aey,
      longint bx, longint by, longint bex, longint bey
   );
      longint cx, cy, xl, xr, yt, yb, el, er, et, eb, r2;
      bit horiz, vert;
      case (operation)
         OP_RECT_RECT:
            return (2 * magnitude(ax - bx) <= aex + bex) &&
                   (2 * magnitude(ay - by) <= aey + bey);
         OP_CIRCLE_CIRCLE:
            return within_radius(ax - bx, ay - by, aex + bex);
         OP_RECT_CIRCLE: begin
            // Everything is doubled so that half extents stay whole numbers.
            cx = 2 * bx;
            cy = 2 * by;
            xl = 2 * ax - aex;
            xr = 2 * ax + aex;
            yt = 2 * ay - aey;
            yb = 2 * ay + aey;
            el = xl - cx;
            er = xr - cx;
            et = yt - cy;
            eb = yb - cy;
            r2 = 2 * bex;
            horiz = (cx >= xl) && (cx <= xr);
            vert = (cy >= yt) && (cy <= yb);
            return (horiz && vert) ||
                   within_radius(el, et, r2) || within_radius(er, et, r2) ||
                   within_radius(el, eb, r2) || within_radius(er, eb, r2) ||
                   (horiz && ay >= by && magnitude(et) <= r2) ||
                   (horiz && ay <= by && magnitude(eb) <= r2) ||
                   (vert && ax >= bx && magnitude(el) <= r2) ||
                   (vert && ax <= bx && magnitude(er) <= r2);
         end
         default:
            return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         expected_collides.delete();
      end else begin
         if (start && !busy) begin
            expected_collides.push_back(predict_collision(req_operation,
               longint'(req_first_x), longint'(req_first_y),
               longint'(req_first_extent_x), longint'(req_first_extent_y),
               longint'(req_second_x), longint'(req_second_y),
               longint'(req_second_extent_x), longint'(req_second_extent_y)));
         end
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid is unknown");
            error_count++;
         end else if (rsp_valid) begin
            if (expected_collides.size() == 0) begin
               $error("response with no request waiting: collides %0b", rsp_collides);
               error_count++;
            end else begin
               want = expected_collides.pop_front();
               if (rsp_collides !== want) begin
                  $error("collides: expected %0b, actual %0b", want, rsp_collides);
                  error_count++;
               end
            end
         end
      end
      mismatches <= error_count;
      pending <= expected_collides.size();
   end

endmodule

// File: sim/tb_top.sv
// Testbench top for the shape collision tester: stimulus, clock, reset and verdict.
module tb_top;
   import scl_pkg::*;

   localparam int COORD_WIDTH = 16;
   localparam int CYCLE_LIMIT = 50000;
   localparam int RANDOM_REQUESTS = 900;
   // Selector value with no test behind it; the block must answer no collision.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                    operation;
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic        [COORD_WIDTH-2:0] first_extent_x;
      logic        [COORD_WIDTH-2:0] first_extent_y;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic        [COORD_WIDTH-2:0] second_extent_x;
      logic        [COORD_WIDTH-2:0] second_extent_y;
   } shape_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic signed [COORD_WIDTH-1:0] req_first_x = '0;
   logic signed [COORD_WIDTH-1:0] req_first_y = '0;
   logic [COORD_WIDTH-2:0] req_first_extent_x = '0;
   logic [COORD_WIDTH-2:0] req_first_extent_y = '0;
   logic signed [COORD_WIDTH-1:0] req_second_x = '0;
   logic signed [COORD_WIDTH-1:0] req_second_y = '0;
   logic [COORD_WIDTH-2:0] req_second_extent_x = '0;
   logic [COORD_WIDTH-2:0] req_second_extent_y = '0;
   logic rsp_valid;
   logic rsp_collides;
   int mismatches;
   int pending;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   always #5 clock = ~clock;

   shape_collision_tester_unit #(.COORD_WIDTH(COORD_WIDTH)) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_first_x         (req_first_x),
      .req_first_y         (req_first_y),
      .req_first_extent_x  (req_first_extent_x),
      .req_first_extent_y  (req_first_extent_y),
      .req_second_x        (req_second_x),
      .req_second_y        (req_second_y),
      .req_second_extent_x (req_second_extent_x),
      .req_second_extent_y (req_second_extent_y),
      .rsp_valid           (rsp_valid),
      .rsp_collides        (rsp_collides)
   );

   collision_checker #(.COORD_WIDTH(COORD_WIDTH)) scoreboard (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_first_x         (req_first_x),
      .req_first_y         (req_first_y),
      .req_first_extent_x  (req_first_extent_x),
      .req_first_extent_y  (req_first_extent_y),
      .req_second_x        (req_second_x),
      .req_second_y        (req_second_y),
      .req_second_extent_x (req_second_extent_x),
      .req_second_extent_y (req_second_extent_y),
      .rsp_valid           (rsp_valid),
      .rsp_collides        (rsp_collides),
      .mismatches          (mismatches),
      .pending             (pending)
   );

   function automatic shape_pair_type make_pair(
      logic [1:0] operation, int fx, int fy, int fex, int fey,
      int sx, int sy, int sex, int sey
   );
      shape_pair_type p;
      p.operation = operation;
      p.first_x = 16'(fx);
      p.first_y = 16'(fy);
      p.first_extent_x = 15'(fex);
      p.first_extent_y = 15'(fey);
      p.second_x = 16'(sx);
      p.second_y = 16'(sy);
      p.second_extent_x = 15'(sex);
      p.second_extent_y = 15'(sey);
      return p;
   endfunction

   // Signed offset of up to 2^scale in either direction.
   function automatic int near_offset(int scale);
      return int'($urandom_range(0, 2 << scale)) - (1 << scale);
   endfunction

   // Most pairs sit close together at a shared random scale, so that hits and
   // misses both come up often; the rest is unshaped noise on every bit.
   function automatic shape_pair_type random_pair();
      shape_pair_type p;
      op_type choices[3];
      int unsigned mode;
      int scale;
      choices = '{OP_RECT_RECT, OP_CIRCLE_CIRCLE, OP_RECT_CIRCLE};
      mode = $urandom_range(0, 99);
      if (mode < 20) begin
         p = make_pair(2'($urandom), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end else begin
         scale = $urandom_range(0, 14);
         p.operation = (mode < 24) ? OP_UNUSED : choices[$urandom_range(0, 2)];
         p.first_x = 16'($urandom);
         p.first_y = 16'($urandom);
         p.first_extent_x = 15'($urandom_range(0, 1 << scale));
         p.first_extent_y = 15'($urandom_range(0, 1 << scale));
         p.second_x = 16'(int'(p.first_x) + near_offset(scale));
         p.second_y = 16'(int'(p.first_y) + near_offset(scale));
         p.second_extent_x = 15'($urandom_range(0, 1 << scale));
         p.second_extent_y = 15'($urandom_range(0, 1 << scale));
      end
      return p;
   endfunction

   task automatic send_request(input shape_pair_type p);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= p.operation;
      req_first_x <= p.first_x;
      req_first_y <= p.first_y;
      req_first_extent_x <= p.first_extent_x;
      req_first_extent_y <= p.first_extent_y;
      req_second_x <= p.second_x;
      req_second_y <= p.second_y;
      req_second_extent_x <= p.second_extent_x;
      req_second_extent_y <= p.second_extent_y;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Rectangle pairs: same point, exact touch, one step apart, extremes.
      send_request(make_pair(OP_RECT_RECT, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_pair(OP_RECT_RECT, 0, 0, 32, 8, 16, 0, 0, 8));
      send_request(make_pair(OP_RECT_RECT, 0, 0, 32, 8, 17, 0, 0, 8));
      send_request(make_pair(OP_RECT_RECT, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767));
      send_request(make_pair(OP_RECT_RECT, 32767, -32768, 32767, 32767,
                             32767, -32768, 32767, 32767));
      // Circle pairs: exact touch on a 3-4-5 triangle, one short, extremes.
      send_request(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 20, 0, 30, 40, 30, 0));
      send_request(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 20, 0, 30, 40, 29, 0));
      send_request(make_pair(OP_CIRCLE_CIRCLE, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767));
      send_request(make_pair(OP_CIRCLE_CIRCLE, 5, 5, 0, 0, 5, 5, 0, 0));
      // Rectangle against circle: containment, a corner, and each edge.
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 40, 20, 5, -3, 0, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 13, 14, 5, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 13, 14, 4, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 0, -15, 5, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 0, -15, 4, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 0, 15, 5, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, -15, 0, 5, 0));
      send_request(make_pair(OP_RECT_CIRCLE, 0, 0, 20, 20, 15, 0, 5, 0));
      send_request(make_pair(OP_RECT_CIRCLE, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767));
      send_request(make_pair(OP_RECT_CIRCLE, -1, -1, 32767, 32767,
                             -1, -1, 32767, 32767));
      // The unused selector never reports a collision, even for identical shapes.
      send_request(make_pair(OP_UNUSED, -32768, 32767, 32767, 0,
                             32767, -32768, 0, 32767));
      send_request(make_pair(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // Two stretches run back to back with no gaps at all.
         idle_on = ((i / 150) != 2) && ((i / 150) != 5);
         if (i == RANDOM_REQUESTS / 2) wait_drained();
         send_request(random_pair());
      end
      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatches == 0 && pending == 0) begin
         $display("shape_collision_tester_unit test passed");
      end else begin
         $display("shape_collision_tester_unit test failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("shape_collision_tester_unit test failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
rtl/scl_pkg.sv
rtl/scl_square.sv
rtl/scl_decide.sv
rtl/shape_collision_tester_unit.sv
sim/collision_checker.sv
sim/tb_top.sv
